FILE: hw/rtl/hao_pkg.sv
package hao_pkg;

  localparam int PHASE_W      = 32;
  localparam int COS_BITS     = 10;
  localparam int NUM_PARTIALS = 13;
  localparam int PIDX_W       = 4;
  localparam int QTR          = 1 << (COS_BITS - 2);
  localparam int ROM_AW       = COS_BITS - 1;
  localparam int COS_W        = 15;
  localparam int AMP_W        = 7;
  localparam int SAMPLE_W     = 8;
  localparam int LOOP_W       = 16;
  localparam int CNT_W        = 4;
  localparam int MUL_AW       = 33;
  localparam int MUL_BW       = 32;
  localparam int MUL_PW       = MUL_AW + MUL_BW;
  localparam int SHIFT_W      = 6;
  localparam int CONTRIB_W    = 22;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CNT_W-1:0] PRE_LAST = CNT_W'(NUM_PARTIALS);
  localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(NUM_PARTIALS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = '0;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 7'd100;
  localparam logic [LOOP_W-1:0]  LOOP_LENGTH_RST = 16'd22050;

  localparam logic [CONTRIB_W-1:0] BIAS = CONTRIB_W'(127 * 16384);

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_RUN,
    ST_DONE
  } hao_state_e;

  typedef struct packed {
    logic              start;
    logic              pre_issue;
    logic              run_issue;
    logic [PIDX_W-1:0] idx;
    logic              finish;
  } hao_ctrl_t;

  typedef logic [QTR:0][COS_W-1:0] cos_rom_t;

  // Q1.14 cosine of r/N of a cycle for the first quarter wave
  function automatic logic [COS_W-1:0] quarter_cos(input logic [ROM_AW-1:0] r);
    logic [63:0] theta;
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] t;
    theta = ({{(64-ROM_AW){1'b0}}, r} * TWO_PI_Q30) >> COS_BITS;
    u = (theta * theta) >> 30;
    p = Q30_ONE;
    t = ((u * p) >> 30) / 64'd132;
    p = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t = ((u * p) >> 30) / 64'd90;
    p = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t = ((u * p) >> 30) / 64'd56;
    p = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t = ((u * p) >> 30) / 64'd30;
    p = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t = ((u * p) >> 30) / 64'd12;
    p = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t = ((u * p) >> 30) / 64'd2;
    p = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    return COS_W'((p + 64'd32768) >> 16);
  endfunction

  function automatic cos_rom_t build_cos();
    cos_rom_t rom;
    for (int r = 0; r <= QTR; r++) begin
      rom[r] = quarter_cos(ROM_AW'(r));
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos();

  // harmonic number of partial n: 1, 2, 2, 3, 3, ... 7, 7
  function automatic logic [2:0] part_j(input logic [PIDX_W-1:0] n);
    logic [PIDX_W:0] s;
    s = ({1'b0, n} + 5'd3) >> 1;
    return 3'(s);
  endfunction

  // step = (base * part_mul) >> part_shift; divided partials use reciprocals
  function automatic logic [MUL_AW-1:0] part_mul(input logic [PIDX_W-1:0] n);
    logic [MUL_AW-1:0] m;
    unique case (n)
      4'd0:    m = 33'd1;
      4'd1:    m = 33'd2;
      4'd2:    m = 33'd1;
      4'd3:    m = 33'd3;
      4'd4:    m = 33'h0AAAAAAAB;
      4'd5:    m = 33'd4;
      4'd6:    m = 33'd1;
      4'd7:    m = 33'd5;
      4'd8:    m = 33'h0CCCCCCCD;
      4'd9:    m = 33'd6;
      4'd10:   m = 33'h0AAAAAAAB;
      4'd11:   m = 33'd7;
      4'd12:   m = 33'h124924925;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] part_shift(input logic [PIDX_W-1:0] n);
    logic [SHIFT_W-1:0] s;
    unique case (n)
      4'd2:    s = 6'd1;
      4'd4:    s = 6'd33;
      4'd6:    s = 6'd2;
      4'd8:    s = 6'd34;
      4'd10:   s = 6'd34;
      4'd12:   s = 6'd35;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/hao_mul.sv
module hao_mul (
  input  logic                         clk_i,
  input  logic [hao_pkg::MUL_AW-1:0]   a_i,
  input  logic [hao_pkg::MUL_BW-1:0]   b_i,
  output logic [hao_pkg::MUL_PW-1:0]   prod_o
);
  import hao_pkg::*;

  logic [MUL_PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {{MUL_BW{1'b0}}, a_i} * {{MUL_AW{1'b0}}, b_i};
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/hao_cos_rom.sv
module hao_cos_rom (
  input  logic                        clk_i,
  input  logic [hao_pkg::ROM_AW-1:0]  addr_i,
  output logic [hao_pkg::COS_W-1:0]   data_o
);
  import hao_pkg::*;

  logic [COS_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= COS_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

FILE: hw/rtl/hao_seq.sv
module hao_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_step_i,
  input  logic               out_free_i,
  output logic               in_ready_o,
  output logic               cfg_ready_o,
  output hao_pkg::hao_ctrl_t ctrl_o
);
  import hao_pkg::*;

  hao_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             step_write;

  assign step_write = cfg_valid_i && cfg_step_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (step_write) begin
          state_d = ST_PRE;
        end else if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_PRE: begin
        if (cnt_q == PRE_LAST) state_d = ST_IDLE;
      end
      ST_RUN: begin
        if (cnt_q == RUN_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == ST_PRE || state_q == ST_RUN) cnt_d = cnt_q + 1'b1;
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cfg_ready_o      = 1'b0;
    ctrl_o.start     = 1'b0;
    ctrl_o.pre_issue = 1'b0;
    ctrl_o.run_issue = 1'b0;
    ctrl_o.idx       = cnt_q;
    ctrl_o.finish    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // a step write wins: the step table must be rebuilt first
        cfg_ready_o  = 1'b1;
        in_ready_o   = !step_write;
        ctrl_o.start = in_valid_i && !step_write;
      end
      ST_PRE:  ctrl_o.pre_issue = cnt_q < CNT_W'(NUM_PARTIALS);
      ST_RUN:  ctrl_o.run_issue = cnt_q < CNT_W'(NUM_PARTIALS);
      ST_DONE: ctrl_o.finish = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/harmonic_additive_oscillator_top.sv
// Channel   Dir  Signals                               Beat
// s_axis    in   tvalid tready tdata[7:0]            tdata: [0] restart
// m_axis    out  tvalid tready tdata[7:0] tuser[0:0] tdata: [7:0] sample; tuser: [0] loop_start
// cfg       in   cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  0 phase_step 1 amplitude 2 length
//
// Between input beat and output beat, the 13 partials of a sample pass one at a time
// through the cosine ROM and the shared 33x32 multiplier and are summed into the sample.
// A phase_step write rebuilds the 13-entry step table on the same multiplier, with both
// input and configuration held off. Reset restores the register defaults and clears
// phases, steps and the sample counter at once. A finished sample is held until the
// output register is free or being drained; the block then goes idle for the next input.
module harmonic_additive_oscillator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [0] restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] sample
  output logic [0:0]                      m_axis_tuser,   // [0] loop_start
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hao_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hao_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hao_pkg::*;

  logic [PHASE_W-1:0]  phase_step_q;
  logic [AMP_W-1:0]    amplitude_q;
  logic [LOOP_W-1:0]   loop_length_q;

  logic [PHASE_W-1:0]  phase_q [NUM_PARTIALS];
  logic [PHASE_W-1:0]  step_q  [NUM_PARTIALS];
  logic [LOOP_W-1:0]   sample_index_q;
  logic                first_q;
  logic [SAMPLE_W-1:0] sum_q;

  logic                s1_valid_q, s1_neg_q;
  logic [AMP_W-1:0]    s1_amp_q;
  logic                s2_valid_q, s2_neg_q;
  logic                pw_valid_q;
  logic [PIDX_W-1:0]   pw_idx_q;

  logic                m_valid_q;
  logic [SAMPLE_W-1:0] m_data_q;
  logic                m_first_q;

  hao_ctrl_t           ctrl;
  logic                cfg_acc, out_free;
  logic [LOOP_W-1:0]   len;
  logic                start_clear, end_clear;
  logic [LOOP_W:0]     next_index;
  logic [PHASE_W-1:0]  cur_phase;
  logic [1:0]          quad;
  logic [COS_BITS-3:0] offs;
  logic [ROM_AW-1:0]   rom_addr;
  logic [COS_W-1:0]    rom_data;
  logic [SAMPLE_W-1:0] amp2;
  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic [MUL_PW-1:0]   prod;
  logic [CONTRIB_W-1:0] mag, biased;
  logic [SAMPLE_W-1:0] contrib;

  hao_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .cfg_valid_i (cfg_valid_i),
    .cfg_step_i  (cfg_index_i == REG_PHASE_STEP),
    .out_free_i  (out_free),
    .in_ready_o  (s_axis_tready),
    .cfg_ready_o (cfg_ready_o),
    .ctrl_o      (ctrl)
  );

  hao_cos_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  hao_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= PHASE_STEP_RST;
      amplitude_q   <= AMPLITUDE_RST;
      loop_length_q <= LOOP_LENGTH_RST;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_PHASE_STEP:  phase_step_q  <= cfg_data_i[PHASE_W-1:0];
        REG_AMPLITUDE:   amplitude_q   <= cfg_data_i[AMP_W-1:0];
        REG_LOOP_LENGTH: loop_length_q <= cfg_data_i[LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero length acts as a loop of one sample
  assign len         = (loop_length_q == '0) ? LOOP_W'(1) : loop_length_q;
  assign start_clear = s_axis_tdata[0] || (sample_index_q >= len);
  assign next_index  = {1'b0, sample_index_q} + 1'b1;
  assign end_clear   = next_index >= {1'b0, len};

  // top bits of the phase pick quadrant and offset into the quarter wave
  assign cur_phase = (ctrl.idx < PIDX_W'(NUM_PARTIALS)) ? phase_q[ctrl.idx] : '0;
  assign quad      = cur_phase[PHASE_W-1 -: 2];
  assign offs      = cur_phase[PHASE_W-3 -: COS_BITS-2];
  assign rom_addr  = quad[0] ? ROM_AW'(QTR) - {1'b0, offs} : {1'b0, offs};
  assign amp2      = {amplitude_q, 1'b0};

  always_comb begin
    if (s1_valid_q) begin
      mul_a = MUL_AW'(rom_data);
      mul_b = MUL_BW'(s1_amp_q);
    end else begin
      mul_a = part_mul(ctrl.idx);
      mul_b = phase_step_q;
    end
  end

  assign mag     = prod[CONTRIB_W-1:0];
  assign biased  = s2_neg_q ? BIAS - mag : BIAS + mag;
  assign contrib = biased[CONTRIB_W-1 -: SAMPLE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pw_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl.run_issue;
      s2_valid_q <= s1_valid_q;
      pw_valid_q <= ctrl.pre_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_neg_q <= quad[1] ^ quad[0];
    s1_amp_q <= AMP_W'(amp2 >> part_j(ctrl.idx));
    s2_neg_q <= s1_neg_q;
    pw_idx_q <= ctrl.idx;
    if (ctrl.start) begin
      sum_q   <= '0;
      first_q <= start_clear || (sample_index_q == '0);
    end else if (s2_valid_q) begin
      sum_q <= sum_q + contrib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PARTIALS; i++) begin
        phase_q[i] <= '0;
        step_q[i]  <= '0;
      end
      sample_index_q <= '0;
    end else begin
      if (pw_valid_q) begin
        step_q[pw_idx_q] <= PHASE_W'(prod >> part_shift(pw_idx_q));
      end
      if (ctrl.start && start_clear) begin
        for (int i = 0; i < NUM_PARTIALS; i++) phase_q[i] <= '0;
        sample_index_q <= '0;
      end else if (ctrl.run_issue) begin
        phase_q[ctrl.idx] <= phase_q[ctrl.idx] + step_q[ctrl.idx];
      end else if (ctrl.finish) begin
        if (end_clear) begin
          for (int i = 0; i < NUM_PARTIALS; i++) phase_q[i] <= '0;
          sample_index_q <= '0;
        end else begin
          sample_index_q <= next_index[LOOP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      m_data_q  <= sum_q;
      m_first_q <= first_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_first_q;

endmodule

FILE: verif/tb.sv
module tb;
  import hao_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 700;

  // Predicts each sample from its own copy of the registers, phases and loop counter,
  // and holds the samples still owed by the block.
  class tone_board;
    typedef struct {
      bit [7:0] sample;
      bit       first;
    } tone_t;

    int          cos_tab [1024];
    bit [31:0]   step;
    bit [6:0]    amp;
    bit [15:0]   loop_len;
    bit [31:0]   phase [13];
    int unsigned sample_no;
    tone_t       owed [$];
    int          errors;
    int          matched;
    int          starts;

    function new();
      for (int k = 0; k < 1024; k++) begin
        case (k / 256)
          0:       cos_tab[k] = qcos(k % 256);
          1:       cos_tab[k] = -qcos(256 - k % 256);
          2:       cos_tab[k] = -qcos(k % 256);
          default: cos_tab[k] = qcos(256 - k % 256);
        endcase
      end
      step     = PHASE_STEP_RST;
      amp      = AMPLITUDE_RST;
      loop_len = LOOP_LENGTH_RST;
      clear_loop();
    endfunction

    // Taylor series of cosine in Q30, evaluated by Horner, for a quarter wave
    function int qcos(int r);
      longint unsigned theta;
      longint unsigned u;
      longint unsigned p;
      longint unsigned t;
      longint unsigned divs [6];
      divs  = '{132, 90, 56, 30, 12, 2};
      theta = (longint'(r) * 64'd6746518852) >> 10;
      u     = (theta * theta) >> 30;
      p     = 64'd1 << 30;
      foreach (divs[i]) begin
        t = ((u * p) >> 30) / divs[i];
        p = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
      end
      return int'((p + 64'd32768) >> 16);
    endfunction

    function void clear_loop();
      foreach (phase[i]) phase[i] = '0;
      sample_no = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_PHASE_STEP:  step = data;
        REG_AMPLITUDE:   amp = data[AMP_W-1:0];
        REG_LOOP_LENGTH: loop_len = data[LOOP_W-1:0];
        default: ;
      endcase
    endfunction

    function int partial(bit [31:0] ph, int a);
      int v;
      v = cos_tab[ph[31:22]] * a + 127 * 16384;
      return v >>> 14;
    endfunction

    function void take_restart(bit restart);
      int unsigned len;
      int          a;
      int          n;
      bit [7:0]    acc;
      tone_t       t;
      len = (loop_len == 0) ? 1 : loop_len;
      if (restart || sample_no >= len) clear_loop();
      t.first = (sample_no == 0);
      acc = '0;
      n   = 0;
      for (int unsigned j = 1; j < 8; j++) begin
        a = (int'(amp) * 2) >> j;
        acc = acc + 8'(partial(phase[n], a));
        phase[n] = phase[n] + step * j;
        n++;
        if (j != 1) begin
          acc = acc + 8'(partial(phase[n], a));
          phase[n] = phase[n] + step / j;
          n++;
        end
      end
      sample_no++;
      if (sample_no >= len) clear_loop();
      t.sample = acc;
      owed.push_back(t);
    endfunction

    function void match_sample(logic [7:0] sample, logic first);
      tone_t t;
      if (owed.size() == 0) begin
        $error("unexpected output beat: sample %0d loop_start %0b", sample, first);
        errors++;
        return;
      end
      t = owed.pop_front();
      matched++;
      if (first === 1'b1) starts++;
      if (sample !== t.sample) begin
        $error("sample: expected %0d, actual %0d", t.sample, sample);
        errors++;
      end
      if (first !== t.first) begin
        $error("loop_start: expected %0b, actual %0b", t.first, first);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  tone_board board;
  int        src_idle  = 0;
  int        sink_idle = 0;
  int        cycles    = 0;
  int        sent      = 0;
  int        restarts  = 0;
  int        phases    = 0;

  harmonic_additive_oscillator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: check each accepted beat, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      board.match_sample(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  task automatic push_sample(input bit restart);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.take_restart(restart);
    sent++;
    if (restart) restarts++;
  endtask

  // Leaves valid high unless this is the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (last) cfg_valid_i <= 1'b0;
    board.set_reg(idx, data);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [CFG_IDX_W-1:0] idxs [$];
    logic [31:0]          vals [$];
    logic [15:0]          len;
    if ($urandom_range(0, 3) != 0) begin
      idxs.push_back(REG_PHASE_STEP);
      case ($urandom_range(0, 5))
        0:       vals.push_back(32'h0);
        1:       vals.push_back(32'hFFFF_FFFF);
        2:       vals.push_back($urandom_range(1, 65536));
        default: vals.push_back($urandom);
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      idxs.push_back(REG_AMPLITUDE);
      case ($urandom_range(0, 4))
        0:       vals.push_back({$urandom} & 32'hFFFF_FF80);
        1:       vals.push_back({$urandom} | 32'h7F);
        default: vals.push_back($urandom);
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:          len = 16'd0;
        1:          len = 16'd1;
        2:          len = 16'hFFFF;
        3, 4, 5, 6: len = 16'($urandom_range(2, 60));
        default:    len = 16'($urandom_range(61, 65535));
      endcase
      idxs.push_back(REG_LOOP_LENGTH);
      vals.push_back({16'($urandom), len});
    end
    if ($urandom_range(0, 6) == 0) begin
      idxs.push_back(REG_UNUSED);
      vals.push_back($urandom);
    end
    foreach (idxs[i]) write_reg(idxs[i], vals[i], i == idxs.size() - 1);
  endtask

  initial begin
    int quota;
    board = new();
    src_idle  = 18;
    sink_idle = 74;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults, then a restart
    push_sample(1'b0);
    push_sample(1'b0);
    push_sample(1'b1);
    drain();

    // short loop so the counter wraps, restart in mid-loop
    write_reg(REG_LOOP_LENGTH, 32'd3, 1'b0);
    write_reg(REG_PHASE_STEP, 32'h1000_0000, 1'b1);
    push_sample(1'b0);
    push_sample(1'b0);
    push_sample(1'b0);
    push_sample(1'b1);
    push_sample(1'b0);
    drain();

    // full-scale step and amplitude; zero loop length acts as a loop of one
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0);
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF, 1'b0);
    write_reg(REG_LOOP_LENGTH, 32'hABCD_0000, 1'b1);
    repeat (4) push_sample(1'b0);
    drain();

    // silent amplitude (upper bits dropped), longest loop, write to unused index ignored
    write_reg(REG_AMPLITUDE, 32'h0000_0080, 1'b0);
    write_reg(REG_LOOP_LENGTH, 32'hFFFF_FFFF, 1'b0);
    write_reg(REG_PHASE_STEP, 32'h0040_0001, 1'b0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF, 1'b1);
    repeat (4) push_sample(1'b0);
    drain();

    // shrink the loop below the running counter: next sample starts over
    write_reg(REG_AMPLITUDE, 32'd64, 1'b0);
    write_reg(REG_LOOP_LENGTH, 32'd60, 1'b1);
    repeat (6) push_sample(1'b0);
    drain();
    write_reg(REG_LOOP_LENGTH, 32'd5, 1'b1);
    repeat (3) push_sample(1'b0);
    drain();

    quota = sent + RANDOM_ITEMS;
    while (sent < quota) begin
      if (sent < quota - 450) begin
        src_idle  = 18;
        sink_idle = 74;
      end else if (sent < quota - 220) begin
        src_idle  = 74;
        sink_idle = 18;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end
      random_config();
      phases++;
      repeat ($urandom_range(55, 85)) push_sample($urandom_range(0, 99) < 4);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d samples never came out", board.pending());
      board.errors += board.pending();
    end
    $display("Checked %0d samples over %0d random register settings plus directed cases;",
             board.matched, phases);
    $display("%0d restarts sent, %0d loop starts seen.", restarts, board.starts);
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/hao_pkg.sv
hw/rtl/hao_mul.sv
hw/rtl/hao_cos_rom.sv
hw/rtl/hao_seq.sv
hw/rtl/harmonic_additive_oscillator_top.sv
verif/tb.sv
